// File: design/fbcl_pkg.sv
package fbcl_pkg;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_STAGE = 2'd1,
      REQ_FAULT = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      MODE_BOOT  = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_FAULT = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_READY = 2'd0,
      PHASE_LIT   = 2'd1,
      PHASE_GAP   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      CSR_FAST_PERIOD = 3'd0,
      CSR_SLOW_PERIOD = 3'd1,
      CSR_PULSE       = 3'd2,
      CSR_GAP         = 3'd3,
      CSR_UNKNOWN     = 3'd4
   } csr_index_type;

   localparam logic [1:0] STAGE_RUN   = 2'd1;
   localparam logic [1:0] STAGE_FAULT = 2'd2;

   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int FIELD_CODE_WIDTH = 8;

   typedef struct packed {
      phase_type phase;
      logic      lit;
   } seq_status_type;

   function automatic mode_type mode_of(input logic [1:0] stage, input logic fault_nz);
      mode_type m;
      if (fault_nz || stage == STAGE_FAULT) begin
         m = MODE_FAULT;
      end else if (stage == STAGE_RUN) begin
         m = MODE_RUN;
      end else begin
         m = MODE_BOOT;
      end
      return m;
   endfunction

endpackage

// File: design/fbcl_csr.sv
module fbcl_csr #(
   parameter int TIME_WIDTH = 16,
   parameter int CODE_WIDTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [fbcl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fbcl_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output logic [TIME_WIDTH-1:0]                 fast_period,
   output logic [TIME_WIDTH-1:0]                 slow_period,
   output logic [TIME_WIDTH-1:0]                 pulse_time,
   output logic [TIME_WIDTH-1:0]                 gap_time,
   output logic [CODE_WIDTH-1:0]                 unknown_code
);
   import fbcl_pkg::*;

   localparam logic [31:0] TIME_MAX32 = 32'((64'd1 << TIME_WIDTH) - 64'd1);

   logic [TIME_WIDTH-1:0] fast_ff, slow_ff, pulse_ff, gap_ff;
   logic [CODE_WIDTH-1:0] unknown_ff;
   logic [31:0]           data32;
   logic [TIME_WIDTH-1:0] data_time;

   // saturate intervals that do not fit the countdown
   assign data32    = 32'(csr_data);
   assign data_time = (data32 > TIME_MAX32) ? TIME_WIDTH'(TIME_MAX32)
                                            : data32[TIME_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff    <= TIME_WIDTH'(100);
         slow_ff    <= TIME_WIDTH'(500);
         pulse_ff   <= TIME_WIDTH'(150);
         gap_ff     <= TIME_WIDTH'(800);
         unknown_ff <= CODE_WIDTH'(7);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FAST_PERIOD: fast_ff    <= data_time;
            CSR_SLOW_PERIOD: slow_ff    <= data_time;
            CSR_PULSE:       pulse_ff   <= data_time;
            CSR_GAP:         gap_ff     <= data_time;
            CSR_UNKNOWN:     unknown_ff <= csr_data[CODE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign fast_period  = fast_ff;
   assign slow_period  = slow_ff;
   assign pulse_time   = pulse_ff;
   assign gap_time     = gap_ff;
   assign unknown_code = unknown_ff;

endmodule

// File: design/fbcl_engine.sv
module fbcl_engine #(
   parameter int TIME_WIDTH = 16,
   parameter int CODE_WIDTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [1:0]                      item_type,
   input  logic [1:0]                      item_stage,
   input  logic [CODE_WIDTH-1:0]           item_code,
   input  logic [TIME_WIDTH-1:0]           fast_period,
   input  logic [TIME_WIDTH-1:0]           slow_period,
   input  logic [TIME_WIDTH-1:0]           pulse_time,
   input  logic [TIME_WIDTH-1:0]           gap_time,
   input  logic [CODE_WIDTH-1:0]           unknown_code,
   output logic                            next_level,
   output fbcl_pkg::mode_type              next_mode,
   output fbcl_pkg::seq_status_type        status
);
   import fbcl_pkg::*;

   logic                  lit_ff, lit_in;
   logic [TIME_WIDTH-1:0] rem_ff, rem_in;
   phase_type             phase_ff, phase_in;
   logic [CODE_WIDTH-1:0] done_ff, done_in;
   logic [CODE_WIDTH-1:0] use_ff, use_in;
   logic [1:0]            stage_ff, stage_in;
   logic [CODE_WIDTH-1:0] fault_ff, fault_in;

   mode_type              mode_now;
   logic [TIME_WIDTH-1:0] rem_dec, rem_v;
   logic [CODE_WIDTH-1:0] code_eff, done_v;
   phase_type             phase_v;

   assign mode_now = mode_of(stage_ff, fault_ff != '0);
   assign rem_dec  = (rem_ff != '0) ? rem_ff - TIME_WIDTH'(1) : rem_ff;
   assign code_eff = (fault_ff != '0) ? fault_ff : unknown_code;

   always_comb begin
      lit_in   = lit_ff;
      rem_in   = rem_ff;
      phase_in = phase_ff;
      done_in  = done_ff;
      use_in   = use_ff;
      stage_in = stage_ff;
      fault_in = fault_ff;
      rem_v    = rem_dec;
      done_v   = done_ff;
      phase_v  = phase_ff;
      if (fire) begin
         case (req_kind_type'(item_type))
            REQ_TICK: begin
               if (mode_now == MODE_FAULT) begin
                  // restart the group on a new code
                  if (code_eff != use_ff) begin
                     use_in  = code_eff;
                     phase_v = PHASE_READY;
                     done_v  = '0;
                     lit_in  = 1'b0;
                     rem_v   = '0;
                  end
                  phase_in = phase_v;
                  done_in  = done_v;
                  rem_in   = rem_v;
                  if (rem_v == '0) begin
                     case (phase_v)
                        PHASE_READY: begin
                           if (done_v < code_eff) begin
                              lit_in   = 1'b1;
                              rem_in   = pulse_time;
                              phase_in = PHASE_LIT;
                           end else begin
                              lit_in   = 1'b0;
                              rem_in   = gap_time;
                              phase_in = PHASE_GAP;
                           end
                        end
                        PHASE_LIT: begin
                           lit_in   = 1'b0;
                           rem_in   = pulse_time;
                           done_in  = done_v + CODE_WIDTH'(1);
                           phase_in = PHASE_READY;
                        end
                        default: begin
                           done_in  = '0;
                           phase_in = PHASE_READY;
                           rem_in   = '0;
                        end
                     endcase
                  end
               end else begin
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     lit_in = ~lit_ff;
                     rem_in = (mode_now == MODE_RUN) ? slow_period : fast_period;
                  end
               end
            end
            REQ_STAGE: begin
               stage_in = item_stage;
               if (item_stage != STAGE_FAULT) begin
                  phase_in = PHASE_READY;
                  done_in  = '0;
                  use_in   = '0;
               end
            end
            REQ_FAULT: begin
               fault_in = item_code;
               if (item_code == '0) begin
                  phase_in = PHASE_READY;
                  done_in  = '0;
                  use_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff   <= 1'b0;
         rem_ff   <= '0;
         phase_ff <= PHASE_READY;
         done_ff  <= '0;
         use_ff   <= '0;
         stage_ff <= '0;
         fault_ff <= '0;
      end else begin
         lit_ff   <= lit_in;
         rem_ff   <= rem_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
         use_ff   <= use_in;
         stage_ff <= stage_in;
         fault_ff <= fault_in;
      end
   end

   assign next_level   = lit_in;
   assign next_mode    = mode_of(stage_in, fault_in != '0);
   assign status.phase = phase_ff;
   assign status.lit   = lit_ff;

endmodule

// File: design/fault_blink_code_led.sv
// Status LED blink-code generator.
// Request channel (req_valid / req_stall): one beat is a millisecond tick
// (req_type 0), a stage-class write (1) or a fault-code write (2). Each beat
// yields exactly one response beat on rsp_valid / rsp_stall carrying the LED
// level and the mode (boot, run, fault) after that beat.
// Register channel (csr_valid / csr_ready): csr_ready is always high; index 0
// fast period, 1 slow period, 2 pulse time, 3 gap time, 4 unknown code.
// Write registers only while no beat is in flight.
// Path: a beat accepted into the input register moves through the state
// update into the response register. Throughput: one beat per cycle while
// rsp_stall is low, set by the single state update between the two registers.
// When rsp_stall is high with a response waiting, the input register still
// fills; req_stall rises only once both registers hold a beat.
// Reset (synchronous, active high) empties both registers, darkens the LED,
// selects boot mode with no fault and restores the register defaults
// (100, 500, 150, 800 ms, unknown code 7). The first tick after reset
// toggles the LED.
module fault_blink_code_led #(
   parameter int TIME_WIDTH = 16,
   parameter int CODE_WIDTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_type,
   input  logic [1:0]                            req_stage_class,
   input  logic [fbcl_pkg::FIELD_CODE_WIDTH-1:0] req_fault_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_led_level,
   output logic [1:0]                            rsp_led_mode,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fbcl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fbcl_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import fbcl_pkg::*;

   logic                  in_vld_ff, in_vld_in;
   logic [1:0]            in_type_ff, in_stage_ff;
   logic [CODE_WIDTH-1:0] in_code_ff;
   logic                  out_vld_ff, out_vld_in;
   logic                  out_level_ff;
   mode_type              out_mode_ff;

   logic                  load_in, advance;
   logic [TIME_WIDTH-1:0] fast_period, slow_period, pulse_time, gap_time;
   logic [CODE_WIDTH-1:0] unknown_code;
   logic                  next_level;
   mode_type              next_mode;
   seq_status_type        status;

   assign advance    = in_vld_ff & (~out_vld_ff | ~rsp_stall);
   assign req_stall  = in_vld_ff & ~advance;
   assign load_in    = req_valid & ~req_stall;
   assign in_vld_in  = load_in | (in_vld_ff & ~advance);
   assign out_vld_in = advance | (out_vld_ff & rsp_stall);
   assign csr_ready  = 1'b1;

   fbcl_csr #(
      .TIME_WIDTH (TIME_WIDTH),
      .CODE_WIDTH (CODE_WIDTH)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid & csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fast_period  (fast_period),
      .slow_period  (slow_period),
      .pulse_time   (pulse_time),
      .gap_time     (gap_time),
      .unknown_code (unknown_code)
   );

   fbcl_engine #(
      .TIME_WIDTH (TIME_WIDTH),
      .CODE_WIDTH (CODE_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .item_type    (in_type_ff),
      .item_stage   (in_stage_ff),
      .item_code    (in_code_ff),
      .fast_period  (fast_period),
      .slow_period  (slow_period),
      .pulse_time   (pulse_time),
      .gap_time     (gap_time),
      .unknown_code (unknown_code),
      .next_level   (next_level),
      .next_mode    (next_mode),
      .status       (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_type_ff  <= req_type;
         in_stage_ff <= req_stage_class;
         in_code_ff  <= req_fault_value[CODE_WIDTH-1:0];
      end
      if (advance) begin
         out_level_ff <= next_level;
         out_mode_ff  <= next_mode;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_led_level = out_level_ff;
   assign rsp_led_mode  = out_mode_ff;

   a_stall_needs_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff)
      else $error("request stalled without a blocked beat");

   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced beat missing on response port");

   a_pulse_lit: assert property (@(posedge clock) disable iff (reset)
      status.phase == PHASE_LIT |-> status.lit)
      else $error("pulse phase active with LED dark");

   a_run_no_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_led_mode == MODE_RUN && !advance) |-> status.phase == PHASE_READY)
      else $error("fault sequence left active outside fault mode");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import fbcl_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] REQ_UNDEFINED   = 2'd3;
   localparam logic [1:0] STAGE_BOOT      = 2'd0;
   localparam logic [1:0] STAGE_UNDEFINED = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] stage;
      logic [7:0] code;
   } blink_req_type;

   typedef struct packed {
      logic     level;
      mode_type mode;
   } led_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_TICK;
   logic [1:0]  req_stage_class = STAGE_BOOT;
   logic [7:0]  req_fault_value = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_led_level;
   logic [1:0]  rsp_led_mode;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_FAST_PERIOD;
   logic [15:0] csr_data = 16'd0;

   fault_blink_code_led dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_stage_class (req_stage_class),
      .req_fault_value (req_fault_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_led_level   (rsp_led_level),
      .rsp_led_mode    (rsp_led_mode),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // predictor copy of registers and state
   logic [15:0] m_fast = 16'd100;
   logic [15:0] m_slow = 16'd500;
   logic [15:0] m_pulse = 16'd150;
   logic [15:0] m_gap = 16'd800;
   logic [7:0]  m_unknown = 8'd7;
   logic        m_lit = 1'b0;
   logic [15:0] m_remain = 16'd0;
   phase_type   m_phase = PHASE_READY;
   logic [7:0]  m_pulses = 8'd0;
   logic [7:0]  m_code_used = 8'd0;
   logic [1:0]  m_stage = STAGE_BOOT;
   logic [7:0]  m_fault = 8'd0;

   blink_req_type  blink_reqs_q[$];
   led_result_type led_forecast_q[$];
   blink_req_type  next_req;
   int          reqs_queued = 0;
   int          reqs_accepted = 0;
   int          mismatches = 0;
   int          cycles = 0;
   int          gap_pct = 0;
   int          stall_pct = 0;
   bit          req_taken = 1'b0;

   function automatic mode_type current_mode();
      if (m_fault != 8'd0 || m_stage == STAGE_FAULT) begin
         return MODE_FAULT;
      end else if (m_stage == STAGE_RUN) begin
         return MODE_RUN;
      end
      return MODE_BOOT;
   endfunction

   function automatic void drop_sequence();
      m_phase = PHASE_READY;
      m_pulses = 8'd0;
      m_code_used = 8'd0;
   endfunction

   function automatic led_result_type next_led_state(input blink_req_type r);
      led_result_type res;
      mode_type    mode;
      logic [7:0]  code;
      case (r.kind)
         REQ_TICK: begin
            mode = current_mode();
            if (m_remain != 16'd0) m_remain = m_remain - 16'd1;
            if (mode == MODE_FAULT) begin
               code = (m_fault != 8'd0) ? m_fault : m_unknown;
               if (code != m_code_used) begin
                  drop_sequence();
                  m_code_used = code;
                  m_lit = 1'b0;
                  m_remain = 16'd0;
               end
               if (m_remain == 16'd0) begin
                  case (m_phase)
                     PHASE_READY: begin
                        if (m_pulses < code) begin
                           m_lit = 1'b1;
                           m_remain = m_pulse;
                           m_phase = PHASE_LIT;
                        end else begin
                           m_lit = 1'b0;
                           m_remain = m_gap;
                           m_phase = PHASE_GAP;
                        end
                     end
                     PHASE_LIT: begin
                        m_lit = 1'b0;
                        m_remain = m_pulse;
                        m_pulses = m_pulses + 8'd1;
                        m_phase = PHASE_READY;
                     end
                     default: begin
                        m_pulses = 8'd0;
                        m_phase = PHASE_READY;
                        m_remain = 16'd0;
                     end
                  endcase
               end
            end else if (m_remain == 16'd0) begin
               m_lit = ~m_lit;
               m_remain = (mode == MODE_RUN) ? m_slow : m_fast;
            end
         end
         REQ_STAGE: begin
            m_stage = r.stage;
            if (r.stage != STAGE_FAULT) drop_sequence();
         end
         REQ_FAULT: begin
            m_fault = r.code;
            if (r.code == 8'd0) drop_sequence();
         end
         default: ;
      endcase
      res.level = m_lit;
      res.mode = current_mode();
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 50) $display("%0t ns: %s", $realtime, what);
   endtask

   task automatic queue_req(input logic [1:0] kind, input logic [1:0] stage,
                            input logic [7:0] code);
      blink_reqs_q.push_back('{kind, stage, code});
      reqs_queued++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (reqs_accepted != reqs_queued || led_forecast_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (!req_valid || req_taken) begin
            if (blink_reqs_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
               next_req = blink_reqs_q.pop_front();
               req_valid <= 1'b1;
               req_type <= next_req.kind;
               req_stage_class <= next_req.stage;
               req_fault_value <= next_req.code;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      led_result_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FAST_PERIOD: m_fast = csr_data;
               CSR_SLOW_PERIOD: m_slow = csr_data;
               CSR_PULSE:       m_pulse = csr_data;
               CSR_GAP:         m_gap = csr_data;
               CSR_UNKNOWN:     m_unknown = csr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (led_forecast_q.size() == 0) begin
               report_mismatch("response beat with nothing outstanding");
            end else begin
               want = led_forecast_q.pop_front();
               if (rsp_led_level !== want.level) begin
                  report_mismatch($sformatf("led_level %b, want %b", rsp_led_level, want.level));
               end
               if (rsp_led_mode !== want.mode) begin
                  report_mismatch($sformatf("led_mode %0d, want %0d", rsp_led_mode, want.mode));
               end
            end
         end
         if (req_taken) begin
            led_forecast_q.push_back(next_led_state('{req_type, req_stage_class,
                                                      req_fault_value}));
            reqs_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [15:0] fast, slow, pulse, gap;
      logic [7:0]  unk;
      int          count;
      int          pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats with the default registers
      queue_req(REQ_TICK, STAGE_UNDEFINED, 8'hFF);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_UNDEFINED, STAGE_UNDEFINED, 8'hAA);
      queue_req(REQ_STAGE, STAGE_RUN, 8'h55);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_STAGE, STAGE_UNDEFINED, 8'h00);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_STAGE, STAGE_FAULT, 8'h00);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_FAULT, STAGE_BOOT, 8'hFF);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_FAULT, STAGE_RUN, 8'h00);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_STAGE, STAGE_BOOT, 8'h00);
      queue_req(REQ_FAULT, STAGE_BOOT, 8'h01);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_FAULT, STAGE_BOOT, 8'h80);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      queue_req(REQ_FAULT, STAGE_BOOT, 8'h00);
      queue_req(REQ_STAGE, STAGE_BOOT, 8'h00);
      queue_req(REQ_TICK, STAGE_BOOT, 8'h00);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin fast = 16'd1; slow = 16'd2; pulse = 16'd1; gap = 16'd2; unk = 8'd1; end
            1: begin fast = 16'd0; slow = 16'd0; pulse = 16'd0; gap = 16'd0; unk = 8'd0; end
            2: begin fast = 16'd3; slow = 16'd5; pulse = 16'd2; gap = 16'd4; unk = 8'd3; end
            3: begin
               fast = 16'hFFFF; slow = 16'hFFFF; pulse = 16'hFFFF; gap = 16'hFFFF;
               unk = 8'hFF;
            end
            6: begin fast = 16'd2; slow = 16'd4; pulse = 16'd1; gap = 16'd1; unk = 8'hFF; end
            default: begin
               fast = 16'($urandom_range(12, 1));
               slow = 16'($urandom_range(20, 1));
               pulse = 16'($urandom_range(4));
               gap = 16'($urandom_range(10));
               unk = 8'($urandom_range(5));
            end
         endcase
         write_reg(CSR_FAST_PERIOD, fast);
         write_reg(CSR_SLOW_PERIOD, slow);
         write_reg(CSR_PULSE, pulse);
         write_reg(CSR_GAP, gap);
         write_reg(CSR_UNKNOWN, {8'($urandom_range(255)), unk});

         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 56; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 56; end
            default: begin gap_pct = 13; stall_pct = 13; end
         endcase

         count = (p == 3) ? 60 : 160;
         for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
               queue_req(REQ_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)));
            end else if (pick < 86) begin
               queue_req(REQ_STAGE, 2'($urandom_range(3)), 8'($urandom_range(255)));
            end else if (pick < 97) begin
               queue_req(REQ_FAULT, 2'($urandom_range(3)),
                         ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(3)));
            end else begin
               queue_req(REQ_UNDEFINED, 2'($urandom_range(3)), 8'($urandom_range(255)));
            end
         end
         wait_drained();
         gap_pct = 0;
         stall_pct = 0;
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
design/fbcl_pkg.sv
design/fbcl_csr.sv
design/fbcl_engine.sv
design/fault_blink_code_led.sv
test/tb_top.sv
